// ===== hdl/hjd_pkg.sv =====
// Package for the headset jack type detector: field widths, register indexes,
// zone layouts, state and code enums shared by all detector modules.
// Depends on nothing.
`default_nettype none

package hjd_pkg;

    // Zone counts of the detector.
    localparam int PLUG_ZONES   = 4;
    localparam int BUTTON_ZONES = 3;

    localparam int ZONE_IDX_W = (PLUG_ZONES > 1) ? $clog2(PLUG_ZONES) : 1;

    // Debounce default: 100 ms of presence at a 10 ms tick.
    localparam int TICK_MS           = 10;
    localparam int DEBOUNCE_MS_PLAIN = 100;

    localparam int ADC_W     = 16;
    localparam int CHECK_W   = 8;
    localparam int HITS_W    = 9;
    localparam int DEB_W     = 4;
    localparam int ZONE_W    = 25;
    localparam int ZONES2_W  = 2 * ZONE_W;
    localparam int BUTTON_W  = 34;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = ZONES2_W;

    localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(DEBOUNCE_MS_PLAIN / TICK_MS);

    // Stream widths.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PLUG_ZONES_LO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLUG_ZONES_HI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_ZONE_0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_ZONE_1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_ZONE_2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_ACTIVE_H = 3'd6;

    // Key identifiers.
    localparam logic [1:0] KEY_PLAY     = 2'd0;
    localparam logic [1:0] KEY_VOL_DOWN = 2'd2;

    typedef enum logic [1:0] {
        MODE_EDGE    = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_PRESS   = 2'd2,
        MODE_RELEASE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_CLASSIFY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_3POLE = 2'd1,
        KIND_4POLE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        KEV_NONE    = 2'd0,
        KEV_PRESS   = 2'd1,
        KEV_RELEASE = 2'd2
    } t_key_event;

    // One jack voltage zone, laid out as in the zone registers.
    typedef struct packed {
        logic               four_pole;
        logic [CHECK_W-1:0] hit_limit;
        logic [ADC_W-1:0]   hi_mv;
    } t_jack_zone;

    // One button window, laid out as in the button registers.
    typedef struct packed {
        logic [1:0]       code;
        logic [ADC_W-1:0] hi_mv;
        logic [ADC_W-1:0] lo_mv;
    } t_button_zone;

    typedef struct packed {
        t_kind kind;
        logic  changed;
        logic  bias_on;
        logic  busy;
    } t_jack_status;

    typedef struct packed {
        t_key_event key_event;
        logic [1:0] key_id;
    } t_key_status;

endpackage

`default_nettype wire

// ===== hdl/headset_jack_type_detector.sv =====
// Top level of the headset jack type detector: input register, config
// registers, jack state machine, button decoder and result register.
// Depends on hjd_pkg, hjd_jack_fsm and hjd_button_dec.
`default_nettype none

// The detector takes one transaction per clock cycle on its input stream
// while back-pressure from the output does not hold it, and returns exactly
// one result transaction for each, in order. Every item passes an input
// register and a result register: the combinational path between them (four
// zone compares, three window compares and the state update) computes the
// result of the held item once the result register is free or drains, and the
// result register offers it on the result stream. A waiting result does not
// block the input register from filling, and back-pressure from the output
// holds both stages. Input tuser carries the item mode (0 detect edge, 1 tick,
// 2 button press, 3 button release); input tdata carries the detect pin
// level and the microphone line sample in millivolts. A detect edge with the
// jack present starts a debounce of debounce_ticks ticks, after which mic bias
// comes on and each tick classifies one sample against the ordered jack
// zones. Losing presence at any check reports no device and drops bias.
// Button transactions produce key events only while a four-pole headset is
// current. Configuration is written through the plain write port and must
// only change while no transaction is in flight.
module headset_jack_type_detector (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Configuration write port.
    input  wire                               i_cfg_we,
    input  wire [hjd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [hjd_pkg::CFG_W-1:0]          i_cfg_data,
    // Input stream.
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: detect_level[0], adc_mv[16:1], zero fill[23:17]
    input  wire [hjd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: mode[1:0]
    input  wire [hjd_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    // Result stream.
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // tdata: jack_kind[1:0], kind_changed[2], mic_bias_on[3],
    //        busy_detecting[4], key_event[6:5], key_id[8:7], zero fill[15:9]
    output logic [hjd_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    // Configuration registers.
    logic [hjd_pkg::ZONES2_W-1:0]   r_plug_zones_lo;
    logic [hjd_pkg::ZONES2_W-1:0]   r_plug_zones_hi;
    logic [hjd_pkg::BUTTON_W-1:0]   r_button_zone [hjd_pkg::BUTTON_ZONES];
    logic [hjd_pkg::DEB_W-1:0]      r_debounce_ticks;
    logic                           r_detect_active_high;

    // Input register.
    logic                           r_in_valid;
    hjd_pkg::t_mode                 r_in_mode;
    logic                           r_in_level;
    logic [hjd_pkg::ADC_W-1:0]      r_in_adc;

    // Result register.
    logic                           r_out_valid;
    logic [hjd_pkg::M_TDATA_W-1:0]  r_out_data;

    logic                           w_step;
    logic                           w_present;
    hjd_pkg::t_jack_zone            w_zones   [hjd_pkg::PLUG_ZONES];
    hjd_pkg::t_button_zone          w_windows [hjd_pkg::BUTTON_ZONES];
    hjd_pkg::t_jack_status          w_jack;
    hjd_pkg::t_key_status           w_key;
    hjd_pkg::t_kind                 w_cur_kind;

    // The held item is processed when the result register is free or drains.
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;
    assign w_present     = (r_in_level == r_detect_active_high);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plug_zones_lo      <= '0;
            r_plug_zones_hi      <= '0;
            r_debounce_ticks     <= hjd_pkg::DEBOUNCE_RESET;
            r_detect_active_high <= 1'b0;
            for (int i = 0; i < hjd_pkg::BUTTON_ZONES; i++) begin
                r_button_zone[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hjd_pkg::REG_PLUG_ZONES_LO: r_plug_zones_lo <= i_cfg_data;
                hjd_pkg::REG_PLUG_ZONES_HI: r_plug_zones_hi <= i_cfg_data;
                hjd_pkg::REG_BUTTON_ZONE_0: begin
                    r_button_zone[0] <= i_cfg_data[hjd_pkg::BUTTON_W-1:0];
                end
                hjd_pkg::REG_BUTTON_ZONE_1: begin
                    if (hjd_pkg::BUTTON_ZONES > 1) begin
                        r_button_zone[1 % hjd_pkg::BUTTON_ZONES] <=
                            i_cfg_data[hjd_pkg::BUTTON_W-1:0];
                    end
                end
                hjd_pkg::REG_BUTTON_ZONE_2: begin
                    if (hjd_pkg::BUTTON_ZONES > 2) begin
                        r_button_zone[2 % hjd_pkg::BUTTON_ZONES] <=
                            i_cfg_data[hjd_pkg::BUTTON_W-1:0];
                    end
                end
                hjd_pkg::REG_DEBOUNCE_TICKS: begin
                    r_debounce_ticks <= i_cfg_data[hjd_pkg::DEB_W-1:0];
                end
                hjd_pkg::REG_DETECT_ACTIVE_H: r_detect_active_high <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Zones 0 and 1 live in the low register, zones 2 and 3 in the high one.
    always_comb begin
        for (int z = 0; z < hjd_pkg::PLUG_ZONES; z++) begin
            if (z / 2 == 0) begin
                w_zones[z] = hjd_pkg::t_jack_zone'(r_plug_zones_lo[(z % 2) * hjd_pkg::ZONE_W +:
                                                                   hjd_pkg::ZONE_W]);
            end else begin
                w_zones[z] = hjd_pkg::t_jack_zone'(r_plug_zones_hi[(z % 2) * hjd_pkg::ZONE_W +:
                                                                   hjd_pkg::ZONE_W]);
            end
        end
        for (int b = 0; b < hjd_pkg::BUTTON_ZONES; b++) begin
            w_windows[b] = hjd_pkg::t_button_zone'(r_button_zone[b]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode  <= hjd_pkg::t_mode'(s_axis_tuser[1:0]);
            r_in_level <= s_axis_tdata[0];
            r_in_adc   <= s_axis_tdata[hjd_pkg::ADC_W:1];
        end
    end

    hjd_jack_fsm u_jack (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_mode           (r_in_mode),
        .i_present        (w_present),
        .i_adc            (r_in_adc),
        .i_debounce_ticks (r_debounce_ticks),
        .i_zones          (w_zones),
        .o_status         (w_jack)
    );

    // Button transactions never change the jack kind, so the kind after the
    // step equals the kind held before it.
    assign w_cur_kind = w_jack.kind;

    hjd_button_dec u_button (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_mode      (r_in_mode),
        .i_four_pole (w_cur_kind == hjd_pkg::KIND_4POLE),
        .i_adc       (r_in_adc),
        .i_windows   (w_windows),
        .o_key       (w_key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= {7'b0, w_key.key_id, w_key.key_event, w_jack.busy,
                           w_jack.bias_on, w_jack.changed, w_jack.kind};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== hdl/hjd_jack_fsm.sv =====
// Jack presence, debounce and zone classification state machine.
// Uses hjd_pkg for zone layout, phase and kind enums.
`default_nettype none

module hjd_jack_fsm (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_step,
    input  hjd_pkg::t_mode                      i_mode,
    input  wire                                 i_present,
    input  wire [hjd_pkg::ADC_W-1:0]            i_adc,
    input  wire [hjd_pkg::DEB_W-1:0]            i_debounce_ticks,
    input  hjd_pkg::t_jack_zone                 i_zones [hjd_pkg::PLUG_ZONES],
    output hjd_pkg::t_jack_status               o_status
);

    hjd_pkg::t_phase             r_phase, n_phase;
    logic [hjd_pkg::DEB_W-1:0]   r_deb, n_deb;
    logic [hjd_pkg::HITS_W-1:0]  r_hits [hjd_pkg::PLUG_ZONES];
    logic [hjd_pkg::HITS_W-1:0]  n_hits [hjd_pkg::PLUG_ZONES];
    hjd_pkg::t_kind              r_kind, n_kind;
    logic                        r_bias, n_bias;

    logic                            w_found;
    logic [hjd_pkg::ZONE_IDX_W-1:0]  w_sel;
    logic [hjd_pkg::HITS_W-1:0]      w_hit_inc;
    logic                            w_apply;
    hjd_pkg::t_kind                  w_apply_kind;
    logic                            w_changed;

    // First zone, in order, whose upper bound covers the sample.
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        for (int i = hjd_pkg::PLUG_ZONES - 1; i >= 0; i--) begin
            if (i_adc <= i_zones[i].hi_mv) begin
                w_found = 1'b1;
                w_sel   = hjd_pkg::ZONE_IDX_W'(i);
            end
        end
    end

    assign w_hit_inc = (r_hits[w_sel] == hjd_pkg::HITS_MAX) ? r_hits[w_sel]
                                                            : r_hits[w_sel] + 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_deb        = r_deb;
        n_hits       = r_hits;
        n_kind       = r_kind;
        n_bias       = r_bias;
        w_apply      = 1'b0;
        w_apply_kind = hjd_pkg::KIND_NONE;
        w_changed    = 1'b0;
        if (i_step) begin
            unique case (i_mode)
                hjd_pkg::MODE_EDGE: begin
                    if (!i_present) begin
                        w_apply = 1'b1;
                        n_bias  = 1'b0;
                        n_phase = hjd_pkg::PH_IDLE;
                        n_deb   = '0;
                    end else begin
                        n_phase = hjd_pkg::PH_DEBOUNCE;
                        n_deb   = i_debounce_ticks;
                    end
                end
                hjd_pkg::MODE_TICK: begin
                    priority if (r_phase == hjd_pkg::PH_IDLE) begin
                        n_phase = hjd_pkg::PH_IDLE;
                    end else if (!i_present) begin
                        w_apply = 1'b1;
                        n_bias  = 1'b0;
                        n_phase = hjd_pkg::PH_IDLE;
                        n_deb   = '0;
                    end else if (r_phase == hjd_pkg::PH_DEBOUNCE) begin
                        if (r_deb <= hjd_pkg::DEB_W'(1)) begin
                            n_deb   = '0;
                            n_phase = hjd_pkg::PH_CLASSIFY;
                            n_bias  = 1'b1;
                            for (int i = 0; i < hjd_pkg::PLUG_ZONES; i++) begin
                                n_hits[i] = '0;
                            end
                        end else begin
                            n_deb = r_deb - 1'b1;
                        end
                    end else if (w_found) begin
                        n_hits[w_sel] = w_hit_inc;
                        if (w_hit_inc > {1'b0, i_zones[w_sel].hit_limit}) begin
                            w_apply      = 1'b1;
                            w_apply_kind = i_zones[w_sel].four_pole ? hjd_pkg::KIND_4POLE
                                                                    : hjd_pkg::KIND_3POLE;
                            n_phase      = hjd_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (w_apply) begin
                if (w_apply_kind != r_kind) begin
                    w_changed = 1'b1;
                    n_kind    = w_apply_kind;
                end
                if (w_apply_kind != hjd_pkg::KIND_4POLE) begin
                    n_bias = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hjd_pkg::PH_IDLE;
            r_deb   <= '0;
            r_kind  <= hjd_pkg::KIND_NONE;
            r_bias  <= 1'b0;
            for (int i = 0; i < hjd_pkg::PLUG_ZONES; i++) begin
                r_hits[i] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_deb   <= n_deb;
            r_kind  <= n_kind;
            r_bias  <= n_bias;
            r_hits  <= n_hits;
        end
    end

    assign o_status.kind    = n_kind;
    assign o_status.changed = w_changed;
    assign o_status.bias_on = n_bias;
    assign o_status.busy    = (n_phase != hjd_pkg::PH_IDLE);

endmodule

`default_nettype wire

// ===== hdl/hjd_button_dec.sv =====
// Headset button decoder: matches press samples to button windows and
// remembers the last key for release events. Uses hjd_pkg.
`default_nettype none

module hjd_button_dec (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_step,
    input  hjd_pkg::t_mode             i_mode,
    input  wire                        i_four_pole,
    input  wire [hjd_pkg::ADC_W-1:0]   i_adc,
    input  hjd_pkg::t_button_zone      i_windows [hjd_pkg::BUTTON_ZONES],
    output hjd_pkg::t_key_status       o_key
);

    logic [1:0] r_last_key, n_last_key;
    logic       w_match;
    logic [1:0] w_code;

    // First window that holds the sample; code 3 reads as volume down.
    always_comb begin
        w_match = 1'b0;
        w_code  = hjd_pkg::KEY_PLAY;
        for (int i = hjd_pkg::BUTTON_ZONES - 1; i >= 0; i--) begin
            if (i_adc >= i_windows[i].lo_mv && i_adc <= i_windows[i].hi_mv) begin
                w_match = 1'b1;
                w_code  = (i_windows[i].code > hjd_pkg::KEY_VOL_DOWN) ? hjd_pkg::KEY_VOL_DOWN
                                                                      : i_windows[i].code;
            end
        end
    end

    always_comb begin
        n_last_key      = r_last_key;
        o_key.key_event = hjd_pkg::KEV_NONE;
        o_key.key_id    = hjd_pkg::KEY_PLAY;
        if (i_four_pole) begin
            if (i_mode == hjd_pkg::MODE_RELEASE) begin
                o_key.key_event = hjd_pkg::KEV_RELEASE;
                o_key.key_id    = r_last_key;
            end else if (i_mode == hjd_pkg::MODE_PRESS && w_match) begin
                o_key.key_event = hjd_pkg::KEV_PRESS;
                o_key.key_id    = w_code;
                n_last_key      = w_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_key <= hjd_pkg::KEY_PLAY;
        end else if (i_step) begin
            r_last_key <= n_last_key;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hjd_checker.sv =====
// Port-level checker for the headset jack type detector, with its bind.
// Depends on headset_jack_type_detector and hjd_pkg.
`default_nettype none

module hjd_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_out_valid,
    input wire                            i_out_ready,
    input wire [hjd_pkg::M_TDATA_W-1:0]   i_out_data
);

    // A stalled result holds its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // Bias is on only while detecting or with a four-pole headset present.
    a_bias_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data[3] |->
            i_out_data[4] || i_out_data[1:0] == hjd_pkg::KIND_4POLE)
        else $error("mic bias on without four-pole headset");

    // Key events appear only with a steady four-pole headset.
    a_key_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data[6:5] != hjd_pkg::KEV_NONE |->
            i_out_data[1:0] == hjd_pkg::KIND_4POLE && !i_out_data[2])
        else $error("key event without four-pole headset");

    // No key event means a zero key identifier.
    a_key_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data[6:5] == hjd_pkg::KEV_NONE |->
            i_out_data[8:7] == hjd_pkg::KEY_PLAY)
        else $error("key id set without key event");

endmodule

bind headset_jack_type_detector hjd_checker u_hjd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (m_axis_tvalid),
    .i_out_ready (m_axis_tready),
    .i_out_data  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb_headset_jack_type_detector.sv =====
// Self-checking testbench for the headset jack type detector: drives the item
// stream and the register port, predicts every result and checks it in order.
// Depends on hjd_pkg and headset_jack_type_detector.
`default_nettype none

module tb_headset_jack_type_detector;

    import hjd_pkg::*;

    // A run that is stuck shows up as a long stretch with no transaction on
    // either stream.
    localparam int QUIET_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    // Button codes that the package does not name.
    localparam logic [1:0] KEY_VOL_UP     = 2'd1;
    localparam logic [1:0] KEY_CODE_SPARE = 2'd3;

    // One expected result transaction, field by field.
    typedef struct packed {
        t_kind       kind;
        logic        changed;
        logic        bias;
        logic        busy;
        t_key_event  kev;
        logic [1:0]  kid;
    } t_jack_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire  [M_TDATA_W-1:0]   m_axis_tdata;

    headset_jack_type_detector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor: a private copy of the register file and of the detector
    // state, advanced once per accepted input transaction.
    // ------------------------------------------------------------------
    t_jack_zone          jzone [PLUG_ZONES];
    t_button_zone        bzone [BUTTON_ZONES];
    logic [DEB_W-1:0]    deb_ticks;
    logic                act_high;

    t_phase              ph;
    logic [DEB_W-1:0]    deb_left;
    logic [HITS_W-1:0]   hits [PLUG_ZONES];
    t_kind               kind_now;
    logic [1:0]          last_key;
    logic                bias;
    logic                kind_flag;

    t_jack_result        status_q [$];
    t_jack_result        want;
    t_jack_result        got;

    int                  items_sent = 0;
    int                  fail_count = 0;
    int                  reports = 0;
    int                  quiet_cycles = 0;
    int                  src_idle_pct = 0;
    int                  sink_stall_pct = 0;

    function automatic void reset_predictor();
        for (int z = 0; z < PLUG_ZONES; z++) begin
            jzone[z] = '0;
            hits[z]  = '0;
        end
        for (int b = 0; b < BUTTON_ZONES; b++) begin
            bzone[b] = '0;
        end
        deb_ticks = DEBOUNCE_RESET;
        act_high  = 1'b0;
        ph        = PH_IDLE;
        deb_left  = '0;
        kind_now  = KIND_NONE;
        last_key  = KEY_PLAY;
        bias      = 1'b0;
    endfunction

    // A new type raises the change flag; anything but a four-pole headset
    // drops mic bias, even when the type is reported again unchanged.
    function automatic void set_kind(t_kind k);
        if (k != kind_now) begin
            kind_now  = k;
            kind_flag = 1'b1;
        end
        if (k != KIND_4POLE) begin
            bias = 1'b0;
        end
    endfunction

    function automatic void unplug();
        set_kind(KIND_NONE);
        bias     = 1'b0;
        ph       = PH_IDLE;
        deb_left = '0;
    endfunction

    // The first zone whose upper bound covers the sample takes the hit; a
    // sample above every zone is simply dropped.
    function automatic void classify_sample(logic [ADC_W-1:0] adc);
        logic done;
        done = 1'b0;
        for (int z = 0; z < PLUG_ZONES; z++) begin
            if (!done && adc <= jzone[z].hi_mv) begin
                done = 1'b1;
                if (hits[z] != HITS_MAX) begin
                    hits[z] = hits[z] + 1'b1;
                end
                if (hits[z] > {1'b0, jzone[z].hit_limit}) begin
                    set_kind(jzone[z].four_pole ? KIND_4POLE : KIND_3POLE);
                    ph = PH_IDLE;
                end
            end
        end
    endfunction

    function automatic t_jack_result predict_status(t_mode mode, logic level,
                                                    logic [ADC_W-1:0] adc);
        t_jack_result r;
        logic         present;
        logic         found;
        logic [1:0]   code;
        present   = (level == act_high);
        kind_flag = 1'b0;
        found     = 1'b0;
        r.kev     = KEV_NONE;
        r.kid     = KEY_PLAY;
        case (mode)
            MODE_EDGE: begin
                if (!present) begin
                    unplug();
                end else begin
                    // A new edge restarts the debounce, busy or not.
                    ph       = PH_DEBOUNCE;
                    deb_left = deb_ticks;
                end
            end
            MODE_TICK: begin
                if (ph == PH_IDLE) begin
                    // Ticks while idle change nothing.
                end else if (!present) begin
                    unplug();
                end else if (ph == PH_DEBOUNCE) begin
                    // A debounce count of zero behaves like one.
                    if (deb_left <= 1) begin
                        deb_left = '0;
                        ph       = PH_CLASSIFY;
                        bias     = 1'b1;
                        for (int z = 0; z < PLUG_ZONES; z++) begin
                            hits[z] = '0;
                        end
                    end else begin
                        deb_left = deb_left - 1'b1;
                    end
                end else begin
                    classify_sample(adc);
                end
            end
            default: begin
                // Buttons only count while a four-pole headset is current.
                if (kind_now == KIND_4POLE) begin
                    if (mode == MODE_RELEASE) begin
                        r.kev = KEV_RELEASE;
                        r.kid = last_key;
                    end else begin
                        for (int b = 0; b < BUTTON_ZONES; b++) begin
                            if (!found && adc >= bzone[b].lo_mv &&
                                adc <= bzone[b].hi_mv) begin
                                found = 1'b1;
                                code  = (bzone[b].code > KEY_VOL_DOWN) ? KEY_VOL_DOWN
                                                                       : bzone[b].code;
                                last_key = code;
                                r.kev    = KEV_PRESS;
                                r.kid    = code;
                            end
                        end
                    end
                end
            end
        endcase
        r.kind    = kind_now;
        r.changed = kind_flag;
        r.bias    = bias;
        r.busy    = (ph != PH_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Inputs change on the falling edge; handshakes are judged on
    // the rising edge from the values that were stable before it.
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_PLUG_ZONES_LO: begin
                jzone[0] = data[ZONE_W-1:0];
                jzone[1] = data[ZONES2_W-1:ZONE_W];
            end
            REG_PLUG_ZONES_HI: begin
                jzone[2] = data[ZONE_W-1:0];
                jzone[3] = data[ZONES2_W-1:ZONE_W];
            end
            REG_BUTTON_ZONE_0:   bzone[0] = data[BUTTON_W-1:0];
            REG_BUTTON_ZONE_1:   bzone[1] = data[BUTTON_W-1:0];
            REG_BUTTON_ZONE_2:   bzone[2] = data[BUTTON_W-1:0];
            REG_DEBOUNCE_TICKS:  deb_ticks = data[DEB_W-1:0];
            REG_DETECT_ACTIVE_H: act_high = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sends one input transaction after a random idle gap. tvalid stays high
    // after acceptance so that back-to-back items need no bubble; whoever
    // comes next either drives the following item or lowers it.
    task automatic send_item(t_mode mode, logic level, logic [ADC_W-1:0] adc);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-ADC_W-1){1'b0}}, adc, level};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        status_q.push_back(predict_status(mode, level, adc));
        items_sent++;
    endtask

    // Stops the stream and waits until every result is back, so that the
    // registers may be rewritten.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Receiver: ready is redrawn every cycle from the current stall rate.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checker: every result transaction is compared with the oldest
    // outstanding prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind    = t_kind'(m_axis_tdata[1:0]);
            got.changed = m_axis_tdata[2];
            got.bias    = m_axis_tdata[3];
            got.busy    = m_axis_tdata[4];
            got.kev     = t_key_event'(m_axis_tdata[6:5]);
            got.kid     = m_axis_tdata[8:7];
            if (status_q.size() == 0) begin
                fail_count++;
                reports++;
                if (reports <= MAX_REPORTS) begin
                    $display("%0t: result with nothing outstanding, tdata %h",
                             $realtime, m_axis_tdata);
                end
            end else begin
                want = status_q.pop_front();
                if (got.kind !== want.kind || got.changed !== want.changed ||
                    got.bias !== want.bias || got.busy !== want.busy ||
                    got.kev !== want.kev || got.kid !== want.kid) begin
                    fail_count++;
                    reports++;
                    if (reports <= MAX_REPORTS) begin
                        $display({"%0t: mismatch (expected/actual) kind %0d/%0d ",
                                  "changed %0b/%0b bias %0b/%0b busy %0b/%0b ",
                                  "key event %0d/%0d key id %0d/%0d"},
                                 $realtime, want.kind, got.kind, want.changed,
                                 got.changed, want.bias, got.bias, want.busy,
                                 got.busy, want.kev, got.kev, want.kid, got.kid);
                    end
                end
            end
        end
    end

    // Watchdog on stream activity.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers for the random part.
    // ------------------------------------------------------------------
    // Picks a sample at or below a random zone bound, now and then anything.
    function automatic logic [ADC_W-1:0] zone_sample();
        int z;
        z = $urandom_range(PLUG_ZONES - 1);
        if ($urandom_range(9) == 0) begin
            return ADC_W'($urandom);
        end
        return ADC_W'($urandom_range(jzone[z].hi_mv, 0));
    endfunction

    function automatic logic [ADC_W-1:0] button_sample();
        int b;
        b = $urandom_range(BUTTON_ZONES - 1);
        if ($urandom_range(4) == 0) begin
            return ADC_W'($urandom);
        end
        return ADC_W'($urandom_range(bzone[b].hi_mv, bzone[b].lo_mv));
    endfunction

    // Ordered zone bounds with small check counts, random button windows and
    // random filler above the used bits of the narrower registers.
    task automatic program_random_settings();
        logic [ADC_W-1:0] hs [PLUG_ZONES];
        logic [ADC_W-1:0] tmp;
        t_jack_zone       z [PLUG_ZONES];
        t_button_zone     b;
        for (int i = 0; i < PLUG_ZONES; i++) begin
            hs[i] = ADC_W'($urandom);
        end
        for (int i = 0; i < PLUG_ZONES - 1; i++) begin
            for (int j = 0; j < PLUG_ZONES - 1 - i; j++) begin
                if (hs[j] > hs[j+1]) begin
                    tmp     = hs[j];
                    hs[j]   = hs[j+1];
                    hs[j+1] = tmp;
                end
            end
        end
        if ($urandom_range(3) == 0) begin
            hs[PLUG_ZONES-1] = '1;
        end
        for (int i = 0; i < PLUG_ZONES; i++) begin
            z[i].hi_mv     = hs[i];
            z[i].hit_limit = ($urandom_range(9) == 0) ? CHECK_W'($urandom_range(20))
                                                      : CHECK_W'($urandom_range(3));
            z[i].four_pole = 1'($urandom_range(1));
        end
        write_reg(REG_PLUG_ZONES_LO, {z[1], z[0]});
        write_reg(REG_PLUG_ZONES_HI, {z[3], z[2]});
        for (int i = 0; i < BUTTON_ZONES; i++) begin
            b.lo_mv = ADC_W'($urandom);
            b.hi_mv = ADC_W'($urandom_range(ADC_W'('1), b.lo_mv));
            b.code  = 2'($urandom_range(3));
            write_reg(CFG_IDX_W'(REG_BUTTON_ZONE_0 + i),
                      {(CFG_W-BUTTON_W)'($urandom), b});
        end
        write_reg(REG_DEBOUNCE_TICKS, CFG_W'({$urandom, $urandom}));
        write_reg(REG_DETECT_ACTIVE_H, CFG_W'({$urandom, $urandom}));
    endtask

    // One plug session: edge, debounce, classification, a few button
    // transactions and sometimes an unplug. Some sessions are pure noise,
    // and noise is sprinkled into the debounce and the classification.
    task automatic run_plug_session();
        logic pl;
        int   k;
        pl = act_high;
        if ($urandom_range(99) < 15) begin
            send_item(t_mode'($urandom_range(3)), 1'($urandom_range(1)),
                      ADC_W'($urandom));
            return;
        end
        send_item(MODE_EDGE, pl, ADC_W'($urandom));
        k = 0;
        while (ph == PH_DEBOUNCE && k < 60) begin
            if ($urandom_range(19) == 0) begin
                send_item(t_mode'($urandom_range(3)), 1'($urandom_range(1)),
                          ADC_W'($urandom));
            end else begin
                send_item(MODE_TICK, pl, ADC_W'($urandom));
            end
            k++;
        end
        k = 0;
        while (ph == PH_CLASSIFY && k < 40) begin
            send_item(MODE_TICK, ($urandom_range(29) == 0) ? ~pl : pl, zone_sample());
            k++;
        end
        repeat ($urandom_range(6)) begin
            if ($urandom_range(3) == 0) begin
                send_item(MODE_RELEASE, 1'($urandom_range(1)), ADC_W'($urandom));
            end else begin
                send_item(MODE_PRESS, 1'($urandom_range(1)), button_sample());
            end
        end
        if ($urandom_range(2) == 0) begin
            send_item(MODE_EDGE, ~pl, ADC_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    // Power-on registers: detect active low, every zone and window zero.
    // Covers a tick while idle, buttons without a headset, an edge with the
    // jack absent and a debounce cut short by pin loss.
    task automatic test_power_on_defaults();
        send_item(MODE_TICK, 1'b0, 16'h0000);
        send_item(MODE_PRESS, 1'b1, 16'hFFFF);
        send_item(MODE_RELEASE, 1'b0, 16'h0000);
        send_item(MODE_EDGE, 1'b1, 16'h5A5A);
        send_item(MODE_EDGE, 1'b0, 16'hA5A5);
        send_item(MODE_TICK, 1'b1, 16'h0000);
    endtask

    // Hand-picked zones and windows that walk through every special case:
    // zero debounce, a sample above all zones, a release before any press,
    // window bounds, the spare button code, a press between windows, an edge
    // while busy, the same type reported twice and pin loss.
    task automatic test_directed_cases();
        drain_results();
        // Zones: 100 three-pole at once, 1000 four-pole after two hits,
        // 2000 three-pole after three hits, 0xFFFE four-pole at once.
        write_reg(REG_PLUG_ZONES_LO, {1'b1, 8'd1, 16'd1000, 1'b0, 8'd0, 16'd100});
        write_reg(REG_PLUG_ZONES_HI, {1'b1, 8'd0, 16'hFFFE, 1'b0, 8'd2, 16'd2000});
        write_reg(REG_BUTTON_ZONE_0, {16'd0, KEY_PLAY, 16'd50, 16'd0});
        write_reg(REG_BUTTON_ZONE_1, {16'd0, KEY_VOL_UP, 16'd70, 16'd60});
        write_reg(REG_BUTTON_ZONE_2, {16'd0, KEY_CODE_SPARE, 16'd200, 16'd80});
        write_reg(REG_DEBOUNCE_TICKS, '0);
        write_reg(REG_DETECT_ACTIVE_H, CFG_W'(1));
        send_item(MODE_EDGE, 1'b1, 16'd0);
        send_item(MODE_TICK, 1'b1, 16'd0);
        send_item(MODE_TICK, 1'b1, 16'hFFFF);
        send_item(MODE_TICK, 1'b1, 16'd500);
        send_item(MODE_TICK, 1'b1, 16'd1000);
        send_item(MODE_RELEASE, 1'b0, 16'd0);
        send_item(MODE_PRESS, 1'b1, 16'd70);
        send_item(MODE_PRESS, 1'b0, 16'd150);
        send_item(MODE_PRESS, 1'b1, 16'd55);
        send_item(MODE_RELEASE, 1'b1, 16'd0);
        send_item(MODE_EDGE, 1'b1, 16'd0);
        send_item(MODE_EDGE, 1'b1, 16'd0);
        send_item(MODE_TICK, 1'b1, 16'd0);
        send_item(MODE_TICK, 1'b1, 16'd1500);
        send_item(MODE_TICK, 1'b1, 16'd0);
        send_item(MODE_PRESS, 1'b1, 16'd65);
        send_item(MODE_EDGE, 1'b1, 16'd0);
        send_item(MODE_TICK, 1'b1, 16'd0);
        send_item(MODE_TICK, 1'b1, 16'd0);
        send_item(MODE_TICK, 1'b0, 16'd0);
        send_item(MODE_EDGE, 1'b0, 16'd0);
    endtask

    // All registers but the detect polarity at all ones: the longest debounce
    // and a check count of 255, so classification needs 256 hits on one zone.
    task automatic test_check_count_limit();
        int k;
        drain_results();
        src_idle_pct   = 36;
        sink_stall_pct = 36;
        write_reg(REG_PLUG_ZONES_LO, '1);
        write_reg(REG_PLUG_ZONES_HI, '1);
        write_reg(REG_BUTTON_ZONE_0, '1);
        write_reg(REG_BUTTON_ZONE_1, '1);
        write_reg(REG_BUTTON_ZONE_2, '1);
        write_reg(REG_DEBOUNCE_TICKS, '1);
        write_reg(REG_DETECT_ACTIVE_H, '0);
        send_item(MODE_EDGE, 1'b0, ADC_W'($urandom));
        k = 0;
        while (ph != PH_IDLE && k < 300) begin
            send_item(MODE_TICK, 1'b0, ADC_W'($urandom));
            k++;
        end
        send_item(MODE_PRESS, 1'b1, 16'hFFFF);
        send_item(MODE_PRESS, 1'b0, 16'hFFFE);
        send_item(MODE_RELEASE, 1'b1, 16'hFFFF);
        send_item(MODE_EDGE, 1'b1, 16'hFFFF);
    endtask

    // Random sessions under one flow-control setting and fresh registers.
    task automatic test_random_traffic(int n_items, int src_pct, int sink_pct);
        int first;
        drain_results();
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        program_random_settings();
        first = items_sent;
        while (items_sent - first < n_items) begin
            run_plug_session();
        end
    endtask

    initial begin
        reset_predictor();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_defaults();
        test_directed_cases();
        test_check_count_limit();
        test_random_traffic(130, 0, 0);
        test_random_traffic(130, 47, 0);
        test_random_traffic(130, 0, 47);
        test_random_traffic(130, 36, 36);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/hjd_pkg.sv
hdl/hjd_jack_fsm.sv
hdl/hjd_button_dec.sv
hdl/headset_jack_type_detector.sv
hdl/hjd_checker.sv
tb/tb_headset_jack_type_detector.sv
